[hw/rtl/sfpc_pkg.sv]
// ============================================================================
// sfpc_pkg
// Types and constants shared by the sensor frame plausibility check modules.
// ============================================================================
package sfpc_pkg;

  // Event codes carried in the opcode field.
  localparam logic [1:0] OP_SAMPLE    = 2'd0;
  localparam logic [1:0] OP_CRC_ERR   = 2'd1;
  localparam logic [1:0] OP_MALFORMED = 2'd2;
  localparam logic [1:0] OP_DROPPED   = 2'd3;

  // Reading quality codes; anything at or above QUAL_INVALID is invalid.
  localparam logic [1:0] QUAL_GOOD     = 2'd0;
  localparam logic [1:0] QUAL_DEGRADED = 2'd1;
  localparam logic [1:0] QUAL_INVALID  = 2'd2;

  // Bit positions in fault_flags.
  localparam int unsigned FLAG_MALFORMED = 0;
  localparam int unsigned FLAG_CRC       = 1;
  localparam int unsigned FLAG_STALE     = 2;
  localparam int unsigned FLAG_JUMP      = 3;
  localparam int unsigned FLAG_RANGE     = 4;
  localparam int unsigned FLAG_INVALID   = 5;
  localparam int unsigned FLAG_DEGRADED  = 6;
  localparam int unsigned FLAG_DROPPED   = 7;

  // Service state codes.
  localparam logic [1:0] SVC_AVAILABLE   = 2'd0;
  localparam logic [1:0] SVC_UNAVAILABLE = 2'd1;
  localparam logic [1:0] SVC_DEGRADED    = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd3;

  // Configuration reset values.
  localparam logic [63:0] RST_MAX_AGE   = 64'd100000000;
  localparam logic [15:0] RST_MIN_DIST  = 16'd0;
  localparam logic [15:0] RST_MAX_DIST  = 16'd65535;
  localparam logic [7:0]  RST_THRESHOLD = 8'd3;

  localparam logic [7:0] RUN_MAX = 8'd255;

  // Depth of the queue between the classifier and the state stage.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] now_time;
    logic [63:0] sample_time;
    logic [7:0]  alive_count;
    logic [15:0] reading_distance;
    logic [1:0]  reading_quality;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  fault_flags;
    logic [1:0]  service_state;
    logic        publish_valid;
    logic [15:0] publish_distance;
    logic [15:0] held_distance;
    logic [7:0]  fault_run;
    logic        degraded_request;
  } out_item_t;

  // Classified event handed from the front to the back.
  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] distance;
  } class_item_t;

  typedef struct packed {
    logic [63:0] max_sample_age;
    logic [15:0] min_distance;
    logic [15:0] max_distance;
    logic [7:0]  degraded_threshold;
  } cfg_t;

endpackage

[hw/rtl/sfpc_front.sv]
// ============================================================================
// sfpc_front
// Classifies each event into a fault bitmask and tracks the alive counter.
// ============================================================================
module sfpc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  sfpc_pkg::in_item_t   item,
  input  sfpc_pkg::cfg_t       cfg,
  output sfpc_pkg::class_item_t cls
);

  logic [7:0]  prev_counter_r;
  logic [7:0]  prev_counter_nxt;
  logic        seen_r;
  logic        seen_nxt;
  logic [64:0] age;
  logic        stale;
  logic        jump;
  logic        out_of_range;
  logic [7:0]  flags;

  // A borrow out of the age subtraction means the sample is from the future.
  assign age          = {1'b0, item.now_time} - {1'b0, item.sample_time};
  assign stale        = age[64] || (age[63:0] > cfg.max_sample_age);
  assign jump         = seen_r && (item.alive_count != (prev_counter_r + 8'd1));
  assign out_of_range = (item.reading_distance < cfg.min_distance) ||
                        (item.reading_distance > cfg.max_distance);

  always_comb begin
    flags = '0;
    case (item.opcode)
      sfpc_pkg::OP_CRC_ERR:   flags[sfpc_pkg::FLAG_CRC]       = 1'b1;
      sfpc_pkg::OP_MALFORMED: flags[sfpc_pkg::FLAG_MALFORMED] = 1'b1;
      sfpc_pkg::OP_DROPPED:   flags[sfpc_pkg::FLAG_DROPPED]   = 1'b1;
      default: begin
        flags[sfpc_pkg::FLAG_STALE] = stale;
        flags[sfpc_pkg::FLAG_JUMP]  = jump;
        flags[sfpc_pkg::FLAG_RANGE] = out_of_range;
        if (item.reading_quality >= sfpc_pkg::QUAL_INVALID) begin
          flags[sfpc_pkg::FLAG_INVALID] = 1'b1;
        end else if (item.reading_quality == sfpc_pkg::QUAL_DEGRADED) begin
          flags[sfpc_pkg::FLAG_DEGRADED] = 1'b1;
        end
      end
    endcase
  end

  assign cls.flags    = flags;
  assign cls.distance = item.reading_distance;

  // Every accepted decoded sample stores its counter, faulty or not.
  always_comb begin
    prev_counter_nxt = prev_counter_r;
    seen_nxt         = seen_r;
    if (accept && (item.opcode == sfpc_pkg::OP_SAMPLE)) begin
      prev_counter_nxt = item.alive_count;
      seen_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_counter_r <= '0;
      seen_r         <= 1'b0;
    end else begin
      prev_counter_r <= prev_counter_nxt;
      seen_r         <= seen_nxt;
    end
  end

endmodule

[hw/rtl/sfpc_queue.sv]
// ============================================================================
// sfpc_queue
// Small FIFO of classified events between the front and the back.
// ============================================================================
module sfpc_queue #(
  parameter int unsigned DEPTH = sfpc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sfpc_pkg::class_item_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output sfpc_pkg::class_item_t head_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sfpc_pkg::class_item_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/sfpc_back.sv]
// ============================================================================
// sfpc_back
// Applies classified events to the fault run and held distance, and holds
// the result beat in the output register.
// ============================================================================
module sfpc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  sfpc_pkg::class_item_t head_data,
  output logic                  pop,
  input  logic [7:0]            threshold,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sfpc_pkg::out_item_t   out_data
);

  logic                run_sat;
  logic [7:0]          fault_run_r;
  logic [7:0]          fault_run_nxt;
  logic [15:0]         last_good_r;
  logic [15:0]         last_good_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  sfpc_pkg::out_item_t out_data_r;
  sfpc_pkg::out_item_t out_data_nxt;
  logic [7:0]          run_inc;
  logic                req;
  logic                clean;

  // The output register refills in the same cycle it is emptied.
  assign pop     = head_valid && (!out_valid_r || !out_stall);
  assign clean   = (head_data.flags == '0);
  assign run_sat = (fault_run_r == sfpc_pkg::RUN_MAX);
  assign run_inc = run_sat ? fault_run_r : fault_run_r + 8'd1;
  assign req     = (run_inc >= threshold);

  always_comb begin
    fault_run_nxt = fault_run_r;
    last_good_nxt = last_good_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (clean) begin
        fault_run_nxt                 = '0;
        last_good_nxt                 = head_data.distance;
        out_data_nxt.fault_flags      = '0;
        out_data_nxt.service_state    = sfpc_pkg::SVC_AVAILABLE;
        out_data_nxt.publish_valid    = 1'b1;
        out_data_nxt.publish_distance = head_data.distance;
        out_data_nxt.held_distance    = head_data.distance;
        out_data_nxt.fault_run        = '0;
        out_data_nxt.degraded_request = 1'b0;
      end else begin
        fault_run_nxt                 = run_inc;
        out_data_nxt.fault_flags      = head_data.flags;
        out_data_nxt.service_state    = req ? sfpc_pkg::SVC_DEGRADED
                                            : sfpc_pkg::SVC_UNAVAILABLE;
        out_data_nxt.publish_valid    = 1'b0;
        out_data_nxt.publish_distance = '0;
        out_data_nxt.held_distance    = last_good_r;
        out_data_nxt.fault_run        = run_inc;
        out_data_nxt.degraded_request = req;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_run_r <= '0;
      last_good_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fault_run_r <= fault_run_nxt;
      last_good_r <= last_good_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/sensor_frame_plausibility_check.sv]
// ============================================================================
// sensor_frame_plausibility_check
// Plausibility check of distance sensor events with fault run tracking.
// ============================================================================
// Usage:
// Each input beat (in_valid, in_stall, in_data) carries one event: a decoded
// sample, a CRC error, a malformed frame or a dropped frame. Each event gives
// exactly one result beat (out_valid, out_stall, out_data) with the fault
// flags, service state, published and held distance and fault run.
// The front classifies an event in the cycle it is accepted and writes it to
// a two-entry queue; the back applies it to the fault run and held distance
// and loads the output register. A result passes the queue and the output
// register; one event per cycle is taken while the receiver does not stall.
// When the receiver stalls, the output register holds its beat and the queue
// fills; in_stall rises once the queue is full and drops once an entry leaves.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// taken, are meant for idle periods and ignore indexes beyond the register
// list. Synchronous reset restores the register defaults and clears the
// counter history, fault run, held distance and queue.
// ============================================================================
module sensor_frame_plausibility_check #(
  parameter int unsigned QUEUE_DEPTH = sfpc_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sfpc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sfpc_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                         cfg_data
);

  sfpc_pkg::cfg_t        cfg_r;
  sfpc_pkg::cfg_t        cfg_nxt;
  sfpc_pkg::class_item_t cls;
  sfpc_pkg::class_item_t head_data;
  logic                  accept;
  logic                  full;
  logic                  head_valid;
  logic                  pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfpc_pkg::CFG_MAX_AGE:   cfg_nxt.max_sample_age     = cfg_data;
        sfpc_pkg::CFG_MIN_DIST:  cfg_nxt.min_distance       = cfg_data[15:0];
        sfpc_pkg::CFG_MAX_DIST:  cfg_nxt.max_distance       = cfg_data[15:0];
        sfpc_pkg::CFG_THRESHOLD: cfg_nxt.degraded_threshold = cfg_data[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_sample_age     <= sfpc_pkg::RST_MAX_AGE;
      cfg_r.min_distance       <= sfpc_pkg::RST_MIN_DIST;
      cfg_r.max_distance       <= sfpc_pkg::RST_MAX_DIST;
      cfg_r.degraded_threshold <= sfpc_pkg::RST_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  sfpc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg_r),
    .cls    (cls)
  );

  sfpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (cls),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  sfpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .threshold  (cfg_r.degraded_threshold),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
